// ===== rtl/core/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared sizes, codes and controller/datapath interface types for the
// linear probing hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Table geometry
  localparam int CAPACITY = 255;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CAP_HALF = CAPACITY / 2;
  localparam int CNT_W    = $clog2(CAP_HALF + 1);

  // Field widths
  localparam int ACT_W   = 2;
  localparam int KEY_W   = 32;
  localparam int HASH_W  = 32;
  localparam int VAL_W   = 32;
  localparam int SLOT_W  = 2;

  // Stream payload layout
  localparam int IN_BITS     = KEY_W + HASH_W + VAL_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + VAL_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Reciprocal reduction of the hash modulo CAPACITY:
  // q_est = (hash * MOD_M) >> MOD_S is q or q - 1, so one correction step is enough.
  localparam int MOD_S = HASH_W + IDX_W - 1;
  localparam int Q_W   = 2 * HASH_W - MOD_S;
  localparam logic [HASH_W-1:0] MOD_M = HASH_W'((64'd1 << MOD_S) / 64'(CAPACITY));

  typedef enum logic [ACT_W-1:0] {
    ACT_GET = 2'd0,
    ACT_PUT = 2'd1,
    ACT_DEL = 2'd2
  } act_e;

  typedef enum logic [SLOT_W-1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request transaction
    logic mod1;    // hash times reciprocal
    logic mod2;    // quotient times capacity
    logic start;   // first probe read
    logic probe;   // evaluate probed slot
    logic finish;  // commit update and load result
  } lpht_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic act_ok;   // incoming action is a known one
    logic hit;      // probed slot holds the key
    logic empty;    // probed slot is empty
    logic out_free; // result register can take a new result
  } lpht_sts_t;

endpackage

// ===== rtl/core/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpht_ctrl
// Request sequencer: hash reduction, probe loop and commit of one request.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  lpht_sts_t sts_i,
  output lpht_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD1  = 6'b000010,
    S_MOD2  = 6'b000100,
    S_MOD3  = 6'b001000,
    S_PROBE = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.act_ok ? S_MOD1 : S_FIN;
        end
      end
      S_MOD1: begin
        cmd_o.mod1 = 1'b1;
        state_d    = S_MOD2;
      end
      S_MOD2: begin
        cmd_o.mod2 = 1'b1;
        state_d    = S_MOD3;
      end
      S_MOD3: begin
        cmd_o.start = 1'b1;
        state_d     = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.hit || sts_i.empty) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/lpht_dp.sv =====
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: request registers, hash modulo pipeline, probe registers, slot
// stores, used slot count and result register.
// ----------------------------------------------------------------------------
module lpht_dp import lpht_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lpht_cmd_t              cmd_i,
  output lpht_sts_t              sts_o,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [ACT_W-1:0]       s_tuser_i,
  output logic                   m_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  input  logic                   m_tready_i
);

  localparam logic [HASH_W-1:0] CAP_H    = HASH_W'(CAPACITY);
  localparam logic [IDX_W:0]    CAP_X    = (IDX_W + 1)'(CAPACITY);
  localparam logic [IDX_W-1:0]  CAP_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(CAP_HALF);

  // Request registers
  logic [ACT_W-1:0]    act_q;
  logic [KEY_W-1:0]    key_q;
  logic [HASH_W-1:0]   hash_q;
  logic [VAL_W-1:0]    vin_q;

  // Modulo pipeline
  logic [2*HASH_W-1:0] prod_q;
  logic [HASH_W-1:0]   qc_q;
  logic [Q_W-1:0]      q_est;
  logic [HASH_W-1:0]   r_full;
  logic [IDX_W:0]      r_est;
  logic [IDX_W:0]      r_mod;

  // Probe state
  logic [IDX_W-1:0]    idx_q, idx_inc, rd_addr;
  logic [IDX_W-1:0]    tomb_q, tgt_q;
  logic                tomb_have_q, hit_q, ins_empty_q;
  logic [VAL_W-1:0]    val_q;
  logic [CNT_W-1:0]    used_q;
  logic [CAPACITY-1:0] vld_q;
  logic                vld_rd_q;

  // Store ports
  logic [SLOT_W-1:0]   st_rdata, st_wdata;
  logic [KEY_W-1:0]    key_rdata;
  logic [VAL_W-1:0]    val_rdata;
  logic                st_we, key_we, val_we, used_inc;
  logic [SLOT_W-1:0]   slot_st;
  logic                is_empty, is_tomb, is_hit;

  // Result register
  logic                m_valid_q, found_q, status_q;
  logic [VAL_W-1:0]    vout_q;
  logic                found_d, status_d;
  logic [VAL_W-1:0]    vout_d;

  // Reduce hash to the first probe slot
  assign q_est   = prod_q[2*HASH_W-1:MOD_S];
  assign r_full  = hash_q - qc_q;
  assign r_est   = r_full[IDX_W:0];
  assign r_mod   = (r_est >= CAP_X) ? r_est - CAP_X : r_est;

  // Next slot with wrap at the top of the table
  assign idx_inc = (idx_q == CAP_LAST) ? '0 : idx_q + 1'b1;
  assign rd_addr = cmd_i.start ? r_mod[IDX_W-1:0] : idx_inc;

  // Classify the slot read in the previous cycle
  assign slot_st  = vld_rd_q ? st_rdata : SLOT_W'(ST_EMPTY);
  assign is_empty = (slot_st == SLOT_W'(ST_EMPTY));
  assign is_tomb  = (slot_st == SLOT_W'(ST_TOMB));
  assign is_hit   = (slot_st == SLOT_W'(ST_USED)) && (key_rdata == key_q);

  assign sts_o.act_ok   = (s_tuser_i == ACT_GET) || (s_tuser_i == ACT_PUT) ||
                          (s_tuser_i == ACT_DEL);
  assign sts_o.hit      = is_hit;
  assign sts_o.empty    = is_empty;
  assign sts_o.out_free = !m_valid_q || m_tready_i;

  // Commit decisions and result of the finished request
  always_comb begin
    st_we    = 1'b0;
    st_wdata = SLOT_W'(ST_USED);
    key_we   = 1'b0;
    val_we   = 1'b0;
    used_inc = 1'b0;
    found_d  = 1'b0;
    vout_d   = '0;
    status_d = 1'b0;
    case (act_q)
      ACT_GET: begin
        found_d = hit_q;
        vout_d  = hit_q ? val_q : '0;
      end
      ACT_PUT: begin
        found_d = hit_q;
        if (hit_q) begin
          val_we = 1'b1;
        end else if (used_q >= CNT_FULL) begin
          status_d = 1'b1;
        end else begin
          st_we    = 1'b1;
          key_we   = 1'b1;
          val_we   = 1'b1;
          used_inc = ins_empty_q;
        end
      end
      ACT_DEL: begin
        found_d  = hit_q;
        st_we    = hit_q;
        st_wdata = SLOT_W'(ST_TOMB);
      end
      default: begin
        found_d = 1'b0;
      end
    endcase
  end

  // Request capture and modulo stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= s_tdata_i[KEY_W-1:0];
      hash_q <= s_tdata_i[KEY_W+HASH_W-1:KEY_W];
      vin_q  <= s_tdata_i[IN_BITS-1:KEY_W+HASH_W];
    end
    if (cmd_i.mod1) begin
      prod_q <= hash_q * MOD_M;
    end
    if (cmd_i.mod2) begin
      qc_q <= HASH_W'(q_est * CAP_H);
    end
  end

  // Probe payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q <= r_mod[IDX_W-1:0];
    end else if (cmd_i.probe) begin
      if (is_hit || is_empty) begin
        tgt_q       <= (!is_hit && tomb_have_q) ? tomb_q : idx_q;
        ins_empty_q <= !tomb_have_q;
        val_q       <= val_rdata;
      end else begin
        idx_q <= idx_inc;
        if (is_tomb && !tomb_have_q) begin
          tomb_q <= idx_q;
        end
      end
    end
    if (cmd_i.finish) begin
      found_q  <= found_d;
      vout_q   <= vout_d;
      status_q <= status_d;
    end
  end

  // Control registers: action, probe flags, count, slot valid bits, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= ACT_GET;
      tomb_have_q <= 1'b0;
      hit_q       <= 1'b0;
      used_q      <= '0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      vld_rd_q <= vld_q[rd_addr];
      if (cmd_i.load) begin
        act_q <= s_tuser_i;
        hit_q <= 1'b0;
      end
      if (cmd_i.start) begin
        tomb_have_q <= 1'b0;
      end else if (cmd_i.probe) begin
        if (is_hit || is_empty) begin
          hit_q <= is_hit;
        end else if (is_tomb) begin
          tomb_have_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (st_we) begin
          vld_q[tgt_q] <= 1'b1;
        end
        if (used_inc) begin
          used_q <= used_q + 1'b1;
        end
      end
      // Hold the result until the transaction completes
      if (cmd_i.finish) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Slot stores
  lpht_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish && st_we),
    .waddr_i (tgt_q),
    .wdata_i (st_wdata),
    .raddr_i (rd_addr),
    .rdata_o (st_rdata)
  );

  lpht_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish && key_we),
    .waddr_i (tgt_q),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  lpht_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish && val_we),
    .waddr_i (tgt_q),
    .wdata_i (vin_q),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {(OUT_TDATA_W - OUT_BITS)'(0), status_q, vout_q, found_q};

endmodule

// ===== rtl/core/linear_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Key/value table with open addressing over 255 slots. Each request gets,
// puts or deletes one key, given with its precomputed hash, and returns one
// result (found, value, status). The probe starts at hash modulo capacity,
// steps up one slot per cycle with wrap, stops at the key or at an empty
// slot, and reuses the first tombstone seen for a new key. A put of a new key
// is refused with status 1 once half the slots have ever been filled.
// Requests are served one at a time: after acceptance the states MOD1, MOD2
// and MOD3 reduce the hash through a reciprocal multiply and issue the first
// read, then PROBE reads at least one slot, one per cycle, bounded by the
// single read port of the slot stores, and FIN loads the result register.
// The next request is accepted in IDLE, which the core enters as the result
// is loaded. An unknown action goes straight from IDLE to FIN and returns
// all zeros. The result register lets the next request be accepted while a
// result waits; a finished request holds until that register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core import lpht_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // key_id, key_hash, value_in
  input  logic [ACT_W-1:0]       s_axis_tuser_i,  // action
  // Result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // found, value_out, status, zero pad
);

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  // Sequencer
  lpht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath and slot stores
  lpht_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tready_i (m_axis_tready_i)
  );

  // Block is busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while previous one in flight");

  // A committed request always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid_o)
    else $error("result not presented after commit");

  // Probe continues until it ends on a hit or an empty slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.probe && !sts.hit && !sts.empty) |=> cmd.probe)
    else $error("probe loop left without terminating slot");

  // Commit only when the result register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("commit while result register still held");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_hash_table_core. Get, put and delete
// requests go in on the request stream, and every result transaction is
// compared field by field against a behavioral table model kept in the bench.
// Directed cases come first: misses, the unknown action, probe wrap, tombstone
// reuse and value update. Random traffic over clustered hashes follows, under
// three idle profiles, and the run ends by filling the table to its limit.
// ----------------------------------------------------------------------------
module tb;
  import lpht_pkg::*;

  // Unknown action code, not a member of act_e
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  // Result tdata layout, lowest bit up: found, value_out, status
  localparam int FOUND_BIT  = 0;
  localparam int VALUE_LSB  = 1;
  localparam int STATUS_BIT = VALUE_LSB + VAL_W;

  localparam int KEY_POOL_SIZE = 200;
  localparam int CORE_POOL     = 40;
  localparam int SETTLE_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 3_000_000;

  // Directed keys and hashes; the first hash lands on the top slot, the
  // second on slot zero
  localparam logic [KEY_W-1:0]  KEY_A    = 32'h0000_0000;
  localparam logic [KEY_W-1:0]  KEY_B    = 32'h5A5A_A5A5;
  localparam logic [KEY_W-1:0]  KEY_C    = 32'hA5A5_5A5A;
  localparam logic [KEY_W-1:0]  KEY_ONES = 32'hFFFF_FFFF;
  localparam logic [HASH_W-1:0] HASH_TOP = 32'hFFFF_FFFE;
  localparam logic [HASH_W-1:0] HASH_LOW = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
    logic             status;
  } lookup_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // key_id, key_hash, value_in
  logic [ACT_W-1:0]       s_tuser = '0;   // action
  logic                   m_axis_tvalid_o;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o; // found, value_out, status, zero pad

  // Table model state
  slot_st_e         tbl_state [CAPACITY];
  logic [KEY_W-1:0] tbl_key   [CAPACITY];
  logic [VAL_W-1:0] tbl_value [CAPACITY];
  int unsigned      tbl_used;

  lookup_result_t   expected_results[$];
  lookup_result_t   oldest;
  logic [KEY_W-1:0]  pool_key  [KEY_POOL_SIZE];
  logic [HASH_W-1:0] pool_hash [KEY_POOL_SIZE];
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      mismatches = 0;
  longint           cycle_count = 0;

  linear_probe_hash_table_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Probe the table model and apply one request; returns the expected result
  function automatic lookup_result_t apply_request(logic [ACT_W-1:0] act,
                                                   logic [KEY_W-1:0] key,
                                                   logic [HASH_W-1:0] hash,
                                                   logic [VAL_W-1:0] val);
    lookup_result_t res;
    int unsigned idx, hit_idx, ins_idx, tomb_idx, n;
    bit present, ins_ok, have_tomb, stop;
    res = '0;
    present = 0;
    ins_ok = 0;
    have_tomb = 0;
    stop = 0;
    hit_idx = 0;
    ins_idx = 0;
    tomb_idx = 0;
    n = 0;
    if (act == ACT_UNKNOWN) return res;
    idx = hash % CAPACITY;
    while (!stop && n < CAPACITY) begin
      if (tbl_state[idx] == ST_EMPTY) begin
        ins_idx = have_tomb ? tomb_idx : idx;
        ins_ok = 1;
        stop = 1;
      end else if (tbl_state[idx] == ST_TOMB) begin
        if (!have_tomb) begin
          have_tomb = 1;
          tomb_idx = idx;
        end
      end else if (tbl_key[idx] == key) begin
        present = 1;
        hit_idx = idx;
        stop = 1;
      end
      if (!stop) idx = (idx + 1) % CAPACITY;
      n++;
    end
    if (!present && !ins_ok && have_tomb) begin
      ins_idx = tomb_idx;
      ins_ok = 1;
    end
    res.found = present;
    case (act)
      ACT_GET: begin
        if (present) res.value = tbl_value[hit_idx];
      end
      ACT_PUT: begin
        if (present) begin
          tbl_value[hit_idx] = val;
        end else if (tbl_used >= CAPACITY / 2 || !ins_ok) begin
          res.status = 1'b1;
        end else begin
          if (tbl_state[ins_idx] == ST_EMPTY) tbl_used++;
          tbl_state[ins_idx] = ST_USED;
          tbl_key[ins_idx] = key;
          tbl_value[ins_idx] = val;
        end
      end
      ACT_DEL: begin
        if (present) tbl_state[hit_idx] = ST_TOMB;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Hash whose first probe slot lies in a window starting just below the top
  function automatic logic [HASH_W-1:0] clustered_hash(int unsigned span);
    int unsigned slot;
    slot = (230 + $urandom_range(span - 1)) % CAPACITY;
    return ($urandom % 16843009) * CAPACITY + slot;
  endfunction

  // Present one request, hold it until accepted, and record its expectation
  task automatic send_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                              logic [HASH_W-1:0] hash, logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, hash, key};
    s_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_results.push_back(apply_request(act, key, hash, val));
    @(negedge clk_i);
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Mostly well-formed requests on pooled keys, with some noise mixed in
  task automatic run_random_traffic(int unsigned n_items, int unsigned pool_size);
    int unsigned sel, pick;
    logic [ACT_W-1:0] act;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(99);
      pick = $urandom_range(pool_size - 1);
      act = (sel < 40) ? ACT_PUT : (sel < 75) ? ACT_GET : ACT_DEL;
      if (sel >= 95)
        send_request(ACT_UNKNOWN, $urandom, $urandom, $urandom);
      else if (sel >= 90)
        send_request(act_e'($urandom_range(2)), pool_key[pick], $urandom, $urandom);
      else
        send_request(act, pool_key[pick], pool_hash[pick], $urandom);
    end
  endtask

  task automatic test_basic_operations();
    set_idle(0, 0);
    send_request(ACT_GET, KEY_A, '0, '0);
    send_request(ACT_DEL, KEY_A, '0, '1);
    send_request(ACT_UNKNOWN, KEY_ONES, HASH_LOW, '1);
    send_request(ACT_PUT, KEY_A, HASH_TOP, '1);
    // same first slot as A: wraps to slot zero
    send_request(ACT_PUT, KEY_B, HASH_TOP, 32'h1234_5678);
    send_request(ACT_GET, KEY_B, HASH_TOP, '0);
    send_request(ACT_PUT, KEY_B, HASH_TOP, '0);
    send_request(ACT_GET, KEY_B, HASH_TOP, '1);
    send_request(ACT_GET, KEY_A, HASH_TOP, '0);
    // leave a tombstone on the top slot, then probe across it
    send_request(ACT_DEL, KEY_A, HASH_TOP, '0);
    send_request(ACT_GET, KEY_B, HASH_TOP, '0);
    send_request(ACT_PUT, KEY_C, HASH_TOP, 32'hDEAD_BEEF);
    send_request(ACT_GET, KEY_C, HASH_TOP, '0);
    send_request(ACT_GET, KEY_A, HASH_TOP, '0);
    send_request(ACT_PUT, KEY_ONES, HASH_LOW, 32'h8000_0001);
    // key present but probed from an unrelated slot
    send_request(ACT_GET, KEY_ONES, 32'h0000_0005, '0);
    send_request(ACT_DEL, KEY_B, HASH_TOP, '0);
    send_request(ACT_GET, KEY_ONES, HASH_LOW, '0);
    send_request(ACT_DEL, KEY_C, HASH_TOP, '0);
    send_request(ACT_DEL, KEY_C, HASH_TOP, '0);
  endtask

  task automatic test_random_slow_receiver();
    set_idle(7, 88);
    run_random_traffic(330, CORE_POOL);
  endtask

  task automatic test_random_slow_sender();
    set_idle(88, 7);
    run_random_traffic(330, CORE_POOL);
  endtask

  task automatic test_random_back_to_back();
    set_idle(0, 0);
    run_random_traffic(330, CORE_POOL);
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0]  last_key;
    logic [HASH_W-1:0] last_hash;
    int unsigned n;
    set_idle(0, 0);
    last_key = '0;
    last_hash = '0;
    n = 0;
    // insert fresh keys until half the slots have been filled
    while (tbl_used < CAPACITY / 2 && n < 400) begin
      last_key = $urandom;
      last_hash = clustered_hash(100);
      send_request(ACT_PUT, last_key, last_hash, $urandom);
      n++;
    end
    send_request(ACT_PUT, $urandom, clustered_hash(100), $urandom);
    send_request(ACT_PUT, last_key, last_hash, '1);
    send_request(ACT_GET, last_key, last_hash, '0);
    send_request(ACT_DEL, last_key, last_hash, '0);
    // tombstone free but count at its limit: still refused
    send_request(ACT_PUT, $urandom, last_hash, $urandom);
    send_request(ACT_PUT, last_key, last_hash, $urandom);
    send_request(ACT_GET, last_key, last_hash, '0);
    run_random_traffic(150, KEY_POOL_SIZE);
  endtask

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        if (m_axis_tdata_o[FOUND_BIT] !== oldest.found) begin
          $error("found: expected %0d, actual %0d", oldest.found,
                 m_axis_tdata_o[FOUND_BIT]);
          mismatches++;
        end
        if (m_axis_tdata_o[VALUE_LSB +: VAL_W] !== oldest.value) begin
          $error("value_out: expected %h, actual %h", oldest.value,
                 m_axis_tdata_o[VALUE_LSB +: VAL_W]);
          mismatches++;
        end
        if (m_axis_tdata_o[STATUS_BIT] !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status,
                 m_axis_tdata_o[STATUS_BIT]);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      tbl_state[i] = ST_EMPTY;
      tbl_key[i] = '0;
      tbl_value[i] = '0;
    end
    tbl_used = 0;
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = clustered_hash(i < CORE_POOL ? 40 : 100);
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_operations();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_back_to_back();
    test_table_full();

    // Drain outstanding results, then let the core settle
    s_tvalid <= 1'b0;
    set_idle(0, 0);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== linear_probe_hash_table_core.f =====
rtl/core/lpht_pkg.sv
rtl/core/lpht_ram.sv
rtl/core/lpht_ctrl.sv
rtl/core/lpht_dp.sv
rtl/core/linear_probe_hash_table_core.sv
tb/sv/tb.sv
